@@ rtl/pta_pkg.sv @@
// Package: shared widths, defaults, command codes and sequencer states.
`default_nettype none
package pta_pkg;

    localparam int PIXELS_DEF   = 4096;
    localparam int LAGS_DEF     = 16;
    localparam int ACC_BITS_DEF = 48;

    localparam int PIX_W     = 12;
    localparam int SAMPLE_W  = 9;
    localparam int LAG_SEL_W = 4;
    localparam int LAG_SUM_W = 48;
    localparam int PROD_W    = 2 * SAMPLE_W;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCUM,
        ST_WRITE,
        ST_READ_ADDR,
        ST_READ_DATA
    } t_pta_state;

endpackage
`default_nettype wire

@@ rtl/pta_if.sv @@
// Interfaces: request channel and result channel with valid/ready handshake.
`default_nettype none
interface pta_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic        [pta_pkg::PIX_W-1:0]      pixel_index;
    logic signed [pta_pkg::SAMPLE_W-1:0]   sample;
    logic        [pta_pkg::LAG_SEL_W-1:0]  lag_select;
    logic                                  frame_end;

    modport source (output valid, command, pixel_index, sample, lag_select, frame_end,
                    input ready);
    modport sink   (input valid, command, pixel_index, sample, lag_select, frame_end,
                    output ready);
endinterface

interface pta_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pta_pkg::LAG_SUM_W-1:0]  lag_sum;
    logic                                  at_limit;
    logic                                  ring_full;

    modport source (output valid, lag_sum, at_limit, ring_full, input ready);
    modport sink   (input valid, lag_sum, at_limit, ring_full, output ready);
endinterface
`default_nettype wire

@@ rtl/pta_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/pta_mac.sv @@
// Shared multiply and saturating accumulate unit: one lag product per cycle.
`default_nettype none
module pta_mac #(
    parameter int ACC_BITS = pta_pkg::ACC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic signed [pta_pkg::SAMPLE_W-1:0] i_a,
    input  wire logic signed [pta_pkg::SAMPLE_W-1:0] i_b,
    input  wire logic signed [ACC_BITS-1:0]          i_acc,
    output      logic                                o_valid,
    output      logic signed [ACC_BITS-1:0]          o_sum
);

    localparam logic signed [ACC_BITS-1:0] AccMax = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] AccMin = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic signed [pta_pkg::PROD_W-1:0] r_prod;
    logic signed [pta_pkg::PROD_W-1:0] n_prod;
    logic                              r_valid;
    logic signed [ACC_BITS:0]          w_sum;

    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (i_valid) begin
            r_prod <= n_prod;
        end
    end

    // One guard bit catches overflow; clamp toward the sign of the true sum.
    assign w_sum = (ACC_BITS+1)'(i_acc) + (ACC_BITS+1)'(r_prod);

    always_comb begin
        if (w_sum[ACC_BITS] != w_sum[ACC_BITS-1]) begin
            o_sum = w_sum[ACC_BITS] ? AccMin : AccMax;
        end else begin
            o_sum = w_sum[ACC_BITS-1:0];
        end
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire

@@ rtl/pixel_temporal_autocorrelation_unit.sv @@
// Top level: per-pixel temporal autocorrelation accumulator with sequencer.
//
//  Port    Dir  Modport  Payload
//  i_in    in   sink     command, pixel_index, sample, lag_select, frame_end
//  o_out   out  source   lag_sum, at_limit, ring_full
//
// After reset the accumulator memory is cleared by a sweep over all PIXELS*LAGS cells;
// no request is taken then. A sample for a full ring goes through ACCUM, one lag per
// cycle on the shared multiply/accumulate unit, then through the lag pipeline, a drain
// check, WRITE for the ring write, and back to IDLE. Any other in-range sample goes
// through WRITE to IDLE, and an out-of-range one stays in IDLE; a read goes through
// READ_ADDR and READ_DATA, plus any wait for the output register, which holds one
// result while the next request is taken.
`default_nettype none
module pixel_temporal_autocorrelation_unit #(
    parameter int PIXELS   = pta_pkg::PIXELS_DEF,
    parameter int LAGS     = pta_pkg::LAGS_DEF,
    parameter int ACC_BITS = pta_pkg::ACC_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    pta_in_if.sink   i_in,
    pta_out_if.source o_out
);

    localparam int CELLS = PIXELS * LAGS;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(LAGS);
    localparam int FW    = $clog2(LAGS + 1);

    localparam logic [AW-1:0] LastCell = AW'(CELLS - 1);
    localparam logic [LW-1:0] LastLag  = LW'(LAGS - 1);
    localparam logic [FW-1:0] FullCnt  = FW'(LAGS);
    localparam logic signed [ACC_BITS-1:0] AccMax = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] AccMin = {1'b1, {(ACC_BITS-1){1'b0}}};

    pta_pkg::t_pta_state r_state;
    pta_pkg::t_pta_state n_state;

    logic [AW-1:0] r_clr;
    logic [LW-1:0] r_oldest;
    logic [FW-1:0] r_frames;

    // Request held for the whole sequence
    logic                                r_cmd;
    logic [AW-1:0]                       r_base;
    logic signed [pta_pkg::SAMPLE_W-1:0] r_sample;
    logic [pta_pkg::LAG_SEL_W-1:0]       r_lag;
    logic                                r_pix_ok;
    logic                                r_lag_ok;
    logic [LW-1:0]                       r_slot;
    logic                                r_full;

    // Lag pipeline
    logic                                r_iss;
    logic [LW-1:0]                       r_j;
    logic [LW-1:0]                       r_bidx;
    logic                                r_v1;
    logic [LW-1:0]                       r_j1;
    logic [LW-1:0]                       r_j2;
    logic signed [pta_pkg::SAMPLE_W-1:0] r_a;

    // Output register
    logic                                 r_out_valid;
    logic signed [pta_pkg::LAG_SUM_W-1:0] r_out_sum;
    logic                                 r_out_lim;
    logic                                 r_out_full;

    logic                                w_in_acc;
    logic                                w_pix_ok;
    logic                                w_lag_ok;
    logic [AW-1:0]                       w_base;
    logic                                w_full;
    logic                                w_issue;
    logic                                w_out_load;
    logic                                w_v2;
    logic signed [ACC_BITS-1:0]          w_sum;

    logic                                ring_we;
    logic [AW-1:0]                       ring_waddr;
    logic [AW-1:0]                       ring_raddr;
    logic [pta_pkg::SAMPLE_W-1:0]        ring_rdata;
    logic signed [pta_pkg::SAMPLE_W-1:0] w_ring_s;
    logic signed [pta_pkg::SAMPLE_W-1:0] w_mac_a;

    logic                                acc_we;
    logic [AW-1:0]                       acc_waddr;
    logic [ACC_BITS-1:0]                 acc_wdata;
    logic                                acc_re;
    logic [AW-1:0]                       acc_raddr;
    logic [ACC_BITS-1:0]                 acc_rdata;
    logic signed [ACC_BITS-1:0]          w_acc_s;
    logic signed [ACC_BITS-1:0]          w_rd_val;

    assign i_in.ready = (r_state == pta_pkg::ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_pix_ok   = 17'(i_in.pixel_index) < 17'(PIXELS);
    assign w_lag_ok   = 7'(i_in.lag_select) < 7'(LAGS);
    assign w_base     = AW'(32'(i_in.pixel_index) * LAGS);
    assign w_full     = (r_frames == FullCnt);
    assign w_issue    = (r_state == pta_pkg::ST_ACCUM) && r_iss;
    assign w_out_load = (r_state == pta_pkg::ST_READ_DATA) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pta_pkg::ST_CLEAR: begin
                if (r_clr == LastCell) begin
                    n_state = pta_pkg::ST_IDLE;
                end
            end
            pta_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.command == pta_pkg::CMD_READ) begin
                        n_state = pta_pkg::ST_READ_ADDR;
                    end else if (w_pix_ok) begin
                        n_state = w_full ? pta_pkg::ST_ACCUM : pta_pkg::ST_WRITE;
                    end
                end
            end
            pta_pkg::ST_ACCUM: begin
                if (!r_iss && !r_v1 && !w_v2) begin
                    n_state = pta_pkg::ST_WRITE;
                end
            end
            pta_pkg::ST_WRITE:     n_state = pta_pkg::ST_IDLE;
            pta_pkg::ST_READ_ADDR: n_state = pta_pkg::ST_READ_DATA;
            pta_pkg::ST_READ_DATA: begin
                if (w_out_load) begin
                    n_state = pta_pkg::ST_IDLE;
                end
            end
            default:               n_state = pta_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pta_pkg::ST_CLEAR;
        end else begin
            r_state  <= n_state;
        end
    end

    // Control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_oldest <= '0;
            r_frames <= '0;
            r_iss    <= 1'b0;
            r_v1     <= 1'b0;
        end else begin
            if (r_state == pta_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            // Frame end moves the ring slot, also for a dropped pixel
            if (w_in_acc && i_in.command == pta_pkg::CMD_SAMPLE && i_in.frame_end) begin
                r_oldest <= (r_oldest == LastLag) ? '0 : r_oldest + LW'(1);
                if (!w_full) begin
                    r_frames <= r_frames + FW'(1);
                end
            end
            if (w_in_acc && i_in.command == pta_pkg::CMD_SAMPLE && w_pix_ok && w_full) begin
                r_iss <= 1'b1;
            end else if (w_issue && r_j == LastLag) begin
                r_iss <= 1'b0;
            end
            r_v1 <= w_issue;
        end
    end

    // Request capture and lag indexes
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= i_in.command;
            r_base   <= w_base;
            r_sample <= i_in.sample;
            r_lag    <= i_in.lag_select;
            r_pix_ok <= w_pix_ok;
            r_lag_ok <= w_lag_ok;
            r_slot   <= r_oldest;
            r_full   <= w_full;
            r_j      <= '0;
            r_bidx   <= r_oldest;
        end else if (w_issue) begin
            r_j    <= r_j + LW'(1);
            r_bidx <= (r_bidx == LastLag) ? '0 : r_bidx + LW'(1);
        end
        if (w_issue) begin
            r_j1 <= r_j;
        end
        if (r_v1) begin
            r_j2 <= r_j1;
            if (r_j1 == '0) begin
                r_a <= w_ring_s;
            end
        end
    end

    // Ring of past samples
    assign ring_we    = (r_state == pta_pkg::ST_WRITE);
    assign ring_waddr = r_base + AW'(r_slot);
    assign ring_raddr = r_base + AW'(r_bidx);
    assign w_ring_s   = signed'(ring_rdata);

    pta_ram #(
        .WIDTH (pta_pkg::SAMPLE_W),
        .DEPTH (CELLS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_sample),
        .i_re    (w_issue),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // Lag zero reads the oldest sample itself, which is also the left factor
    assign w_mac_a = (r_j1 == '0) ? w_ring_s : r_a;
    assign w_acc_s = signed'(acc_rdata);

    pta_mac #(
        .ACC_BITS (ACC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_a     (w_mac_a),
        .i_b     (w_ring_s),
        .i_acc   (w_acc_s),
        .o_valid (w_v2),
        .o_sum   (w_sum)
    );

    // Accumulators: cleared by a sweep after reset
    assign acc_we    = (r_state == pta_pkg::ST_CLEAR) || ((r_state == pta_pkg::ST_ACCUM) && w_v2);
    assign acc_waddr = (r_state == pta_pkg::ST_CLEAR) ? r_clr : r_base + AW'(r_j2);
    assign acc_wdata = (r_state == pta_pkg::ST_CLEAR) ? '0 : w_sum;
    assign acc_re    = r_v1 || (r_state == pta_pkg::ST_READ_ADDR);
    assign acc_raddr = (r_state == pta_pkg::ST_READ_ADDR) ? r_base + AW'(r_lag)
                                                          : r_base + AW'(r_j1);

    pta_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (CELLS)
    ) u_acc (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_re    (acc_re),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // Result register
    assign w_rd_val = (r_pix_ok && r_lag_ok) ? w_acc_s : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_out_sum  <= pta_pkg::LAG_SUM_W'(w_rd_val);
            r_out_lim  <= r_pix_ok && r_lag_ok && (w_acc_s == AccMax || w_acc_s == AccMin);
            r_out_full <= r_full;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.lag_sum   = r_out_sum;
    assign o_out.at_limit  = r_out_lim;
    assign o_out.ring_full = r_out_full;

    a_no_acc_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pta_pkg::ST_IDLE) |-> !acc_we)
        else $error("accumulator written while idle");

    a_stage1_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(w_issue))
        else $error("lag stage valid without a ring read");

    a_accum_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pta_pkg::ST_ACCUM && n_state != pta_pkg::ST_ACCUM)
            |-> (!r_iss && !r_v1 && !w_v2))
        else $error("accumulation left with lags in flight");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames <= FullCnt)
        else $error("frame count above ring depth");

    a_read_uses_read_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (r_cmd == pta_pkg::CMD_READ))
        else $error("result produced for a sample request");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the per-pixel temporal lag accumulator: directed and random requests.
module tb_top;

    localparam int     PIXELS        = pta_pkg::PIXELS_DEF;
    localparam int     LAGS          = pta_pkg::LAGS_DEF;
    localparam int     ACC_BITS      = pta_pkg::ACC_BITS_DEF;
    localparam int     ACTIVE_PIX    = 16;
    localparam int     RANDOM_ITEMS  = 1600;
    localparam longint CYCLE_LIMIT   = 1000000;
    localparam int     SETTLE_CYCLES = 2 * (LAGS + 5);
    localparam longint ACC_MAX       = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
    localparam longint ACC_MIN       = -ACC_MAX - 64'sd1;

    typedef struct packed {
        logic                                 command;
        logic        [pta_pkg::PIX_W-1:0]     pixel_index;
        logic signed [pta_pkg::SAMPLE_W-1:0]  sample;
        logic        [pta_pkg::LAG_SEL_W-1:0] lag_select;
        logic                                 frame_end;
    } t_lag_request;

    typedef struct packed {
        logic signed [pta_pkg::LAG_SUM_W-1:0] lag_sum;
        logic                                 at_limit;
        logic                                 ring_full;
    } t_lag_result;

    typedef enum int {
        RX_OPEN,
        RX_CHOPPY,
        RX_CHOKED
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    pta_in_if  in_if ();
    pta_out_if out_if ();

    pixel_temporal_autocorrelation_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow state of the block
    logic signed [pta_pkg::SAMPLE_W-1:0] ring_shadow [PIXELS*LAGS];
    longint                              acc_shadow  [PIXELS*LAGS];
    int                                  frames_seen;
    int                                  slot_shadow;
    t_lag_result                         expected_reads [$];

    int       active_pix [ACTIVE_PIX];
    int       error_count;
    longint   cycle_count;
    int       burst_left;
    int       sent_count;
    int       stall_left;
    t_rx_mode stall_mode;

    always #10 i_clk = ~i_clk;

    function automatic longint sat_accumulate(input longint acc, input longint prod);
        longint sum;
        sum = acc + prod;
        if (sum > ACC_MAX) return ACC_MAX;
        if (sum < ACC_MIN) return ACC_MIN;
        return sum;
    endfunction

    task automatic predict_request(input t_lag_request r);
        int          base;
        int          idx;
        int          j;
        longint      oldest;
        longint      v;
        t_lag_result res;
        if (r.command == pta_pkg::CMD_READ) begin
            v = 0;
            if (int'(r.pixel_index) < PIXELS && int'(r.lag_select) < LAGS) begin
                idx = int'(r.pixel_index) * LAGS + int'(r.lag_select);
                v = acc_shadow[idx];
            end
            res.lag_sum   = pta_pkg::LAG_SUM_W'(v);
            res.at_limit  = (v == ACC_MAX || v == ACC_MIN) && v != 0;
            res.ring_full = (frames_seen >= LAGS);
            expected_reads = {expected_reads, res};
        end else begin
            if (int'(r.pixel_index) < PIXELS) begin
                base = int'(r.pixel_index) * LAGS;
                if (frames_seen >= LAGS) begin
                    oldest = ring_shadow[base + slot_shadow];
                    for (j = 0; j < LAGS; j++) begin
                        acc_shadow[base + j] = sat_accumulate(acc_shadow[base + j],
                            oldest * longint'(ring_shadow[base + (slot_shadow + j) % LAGS]));
                    end
                end
                ring_shadow[base + slot_shadow] = r.sample;
            end
            if (r.frame_end) begin
                slot_shadow = (slot_shadow + 1) % LAGS;
                if (frames_seen < LAGS) frames_seen++;
            end
        end
    endtask

    function automatic t_lag_request make_sample(input int pix, input int value, input bit fend);
        t_lag_request r;
        r.command     = pta_pkg::CMD_SAMPLE;
        r.pixel_index = pta_pkg::PIX_W'(pix);
        r.sample      = pta_pkg::SAMPLE_W'(value);
        r.lag_select  = pta_pkg::LAG_SEL_W'($urandom);
        r.frame_end   = fend;
        return r;
    endfunction

    function automatic t_lag_request make_read(input int pix, input int lag, input bit fend);
        t_lag_request r;
        r.command     = pta_pkg::CMD_READ;
        r.pixel_index = pta_pkg::PIX_W'(pix);
        r.sample      = pta_pkg::SAMPLE_W'($urandom);
        r.lag_select  = pta_pkg::LAG_SEL_W'(lag);
        r.frame_end   = fend;
        return r;
    endfunction

    function automatic int random_sample();
        int picks [6] = '{-256, -255, 255, 0, -1, 1};
        if ($urandom_range(0, 7) == 0) return picks[$urandom_range(0, 5)];
        return int'($urandom_range(0, 511)) - 256;
    endfunction

    // Drive one request, wait for its handshake, then predict it. Valid stays high.
    task automatic send_request(input t_lag_request r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_if.valid       <= 1'b1;
        in_if.command     <= r.command;
        in_if.pixel_index <= r.pixel_index;
        in_if.sample      <= r.sample;
        in_if.lag_select  <= r.lag_select;
        in_if.frame_end   <= r.frame_end;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_request(r);
        sent_count++;
    endtask

    task automatic hold_until_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reads.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic test_reset_reads();
        send_request(make_read(0, 0, 1'b0));
        // frame_end on a read must not advance the ring
        send_request(make_read(PIXELS - 1, LAGS - 1, 1'b1));
        send_request(make_read($urandom_range(0, PIXELS - 1), $urandom_range(0, LAGS - 1), 1'b1));
    endtask

    task automatic test_ring_fill();
        int f;
        int k;
        int value;
        for (f = 0; f < LAGS; f++) begin
            for (k = 0; k < ACTIVE_PIX; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 0)
                        send_request(make_read($urandom_range(0, PIXELS - 1),
                                               $urandom_range(0, LAGS - 1),
                                               1'($urandom_range(0, 1))));
                    else
                        send_request(make_sample($urandom_range(0, PIXELS - 1),
                                                 random_sample(), 1'b0));
                end
                if (k == 0)      value = -256;
                else if (k == 1) value = 255;
                else             value = random_sample();
                send_request(make_sample(active_pix[k], value, k == ACTIVE_PIX - 1));
            end
            if (f == LAGS - 2) send_request(make_read(active_pix[0], 0, 1'b0));
        end
    endtask

    task automatic test_extremes();
        send_request(make_read(0, 0, 1'b0));
        send_request(make_read(0, LAGS - 1, 1'b0));
        send_request(make_sample(0, -256, 1'b0));
        send_request(make_sample(PIXELS - 1, 255, 1'b0));
        send_request(make_sample(active_pix[2], -255, 1'b0));
        send_request(make_sample(active_pix[3], 0, 1'b0));
        send_request(make_read(0, 0, 1'b0));
        send_request(make_read(0, LAGS - 1, 1'b0));
        send_request(make_read(PIXELS - 1, 0, 1'b0));
        send_request(make_read(PIXELS - 1, LAGS - 1, 1'b1));
        send_request(make_read(active_pix[2], 1, 1'b1));
        send_request(make_sample(0, -256, 1'b1));
        send_request(make_read(0, LAGS / 2, 1'b0));
    endtask

    task automatic test_drain_pause();
        hold_until_drained();
        send_request(make_read(active_pix[1], $urandom_range(0, LAGS - 1), 1'b0));
        send_request(make_sample(active_pix[4], random_sample(), 1'b0));
        send_request(make_read(active_pix[4], 0, 1'b0));
    endtask

    task automatic test_random();
        int start;
        int n;
        int s;
        int pix;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS) begin
            n = $urandom_range(1, 2 * ACTIVE_PIX);
            for (s = 0; s < n; s++) begin
                if ($urandom_range(0, 99) < 35) begin
                    pix = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PIXELS - 1)
                                                      : active_pix[$urandom_range(0, ACTIVE_PIX - 1)];
                    send_request(make_read(pix, $urandom_range(0, LAGS - 1),
                                           1'($urandom_range(0, 1))));
                end
                // only pixels with every ring slot written may take a sample now
                send_request(make_sample(active_pix[$urandom_range(0, ACTIVE_PIX - 1)],
                                         random_sample(), s == n - 1));
            end
            if ($urandom_range(0, 9) == 0) hold_until_drained();
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        t_lag_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_reads.size() == 0) begin
                    $error("result arrived with no read pending");
                    error_count++;
                end else begin
                    want = expected_reads.pop_front();
                    if (out_if.lag_sum !== want.lag_sum) begin
                        $error("lag_sum mismatch: expected %0d, actual %0d",
                               $signed(want.lag_sum), $signed(out_if.lag_sum));
                        error_count++;
                    end
                    if (out_if.at_limit !== want.at_limit) begin
                        $error("at_limit mismatch: expected %0d, actual %0d",
                               want.at_limit, out_if.at_limit);
                        error_count++;
                    end
                    if (out_if.ring_full !== want.ring_full) begin
                        $error("ring_full mismatch: expected %0d, actual %0d",
                               want.ring_full, out_if.ring_full);
                        error_count++;
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = t_rx_mode'($urandom_range(0, 2));
                stall_left = $urandom_range(4, 48);
            end
            stall_left--;
            case (stall_mode)
                RX_OPEN:   out_if.ready <= 1'b1;
                RX_CHOPPY: out_if.ready <= 1'($urandom_range(0, 1));
                default:   out_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int i;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.command     = pta_pkg::CMD_SAMPLE;
        in_if.pixel_index = '0;
        in_if.sample      = '0;
        in_if.lag_select  = '0;
        in_if.frame_end   = 1'b0;
        out_if.ready      = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        burst_left        = 0;
        sent_count        = 0;
        stall_left        = 0;
        stall_mode        = RX_OPEN;
        frames_seen       = 0;
        slot_shadow       = 0;
        for (i = 0; i < PIXELS * LAGS; i++) begin
            ring_shadow[i] = '0;
            acc_shadow[i]  = 0;
        end
        active_pix[0] = 0;
        active_pix[1] = PIXELS - 1;
        for (i = 2; i < ACTIVE_PIX; i++) active_pix[i] = $urandom_range(1, PIXELS - 2);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_reads();
        test_ring_fill();
        test_extremes();
        test_drain_pause();
        test_random();

        in_if.valid <= 1'b0;
        while (expected_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
